>>> rtl/core/tnfd_pkg.sv
// shared types and constants for the tar numeric field decoder
package tnfd_pkg;

  // default for the number of field bytes that take part in decoding
  localparam int FIELD_BYTES_MAX_DEF = 12;

  // one input transaction: a field byte plus the bounds used on the last byte
  typedef struct packed {
    logic [7:0]         field_byte;
    logic               last_byte;
    logic signed [63:0] bound_min;
    logic signed [63:0] bound_max;
  } in_t;

  // one result transaction
  typedef struct packed {
    logic signed [63:0] value;
    logic               in_bounds;
  } out_t;

  // decoded value waiting for the bounds check
  typedef struct packed {
    logic signed [63:0] value;
    logic signed [63:0] bound_min;
    logic signed [63:0] bound_max;
  } cand_t;

endpackage

>>> rtl/core/tnfd_parse.sv
// field parser: running decode state and the registered decoded value
module tnfd_parse #(
  parameter int FIELD_BYTES_MAX = tnfd_pkg::FIELD_BYTES_MAX_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  tnfd_pkg::in_t   item,
  input  logic            down_ready,
  output logic            item_take,
  output logic            cand_valid,
  output tnfd_pkg::cand_t cand
);
  import tnfd_pkg::*;

  localparam int CW = $clog2(FIELD_BYTES_MAX + 1);

  // parse phases
  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_B256   = 3'd1;
  localparam logic [2:0] PH_SPACE  = 3'd2;
  localparam logic [2:0] PH_SIGNED = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]    phase;
  logic [63:0]   acc;
  logic          neg;
  logic [CW-1:0] count;

  logic [2:0]    phase_next;
  logic [63:0]   acc_next;
  logic          neg_next;
  logic [2:0]    phase_eff;
  logic [7:0]    c;
  logic          is_sp;
  logic          is_oct;
  logic          is_sgn;
  logic          cand_ready;
  logic [63:0]   dec_value;

  // a non-last byte never waits; a last byte waits for room in the decoded value register
  assign cand_ready = !cand_valid || down_ready;
  assign item_take  = item_valid && (!item.last_byte || cand_ready);

  // byte classes
  assign c      = item.field_byte;
  assign is_sp  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  assign is_oct = (c >= 8'h30) && (c <= 8'h37);
  assign is_sgn = (c == 8'h2b) || (c == 8'h2d);
  assign phase_eff = (phase == PH_FIRST) ? PH_SPACE : phase;

  // state update for one byte
  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    neg_next   = neg;
    if (count < CW'(FIELD_BYTES_MAX)) begin
      if (phase == PH_FIRST && c[7]) begin
        // base-256: sign-extend the low seven bits
        acc_next   = {{57{c[6]}}, c[6:0]};
        phase_next = PH_B256;
      end else if (phase == PH_B256) begin
        acc_next = {acc[55:0], c};
      end else begin
        unique case (phase_eff)
          PH_SPACE: begin
            if (is_sp) begin
              phase_next = PH_SPACE;
            end else if (is_sgn) begin
              neg_next   = (c == 8'h2d);
              phase_next = PH_SIGNED;
            end else if (is_oct) begin
              acc_next   = {acc[60:0], c[2:0]};
              phase_next = PH_DIGITS;
            end else begin
              phase_next = PH_DONE;
            end
          end
          PH_SIGNED, PH_DIGITS: begin
            if (is_oct) begin
              acc_next   = {acc[60:0], c[2:0]};
              phase_next = PH_DIGITS;
            end else begin
              phase_next = PH_DONE;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // final value, with the octal sign applied
  assign dec_value = (phase_next != PH_B256 && neg_next) ? (64'd0 - acc_next) : acc_next;

  // decode state, cleared after the last byte of a field
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_FIRST;
      acc   <= '0;
      neg   <= 1'b0;
      count <= '0;
    end else if (item_take) begin
      if (item.last_byte) begin
        phase <= PH_FIRST;
        acc   <= '0;
        neg   <= 1'b0;
        count <= '0;
      end else begin
        phase <= phase_next;
        acc   <= acc_next;
        neg   <= neg_next;
        if (count < CW'(FIELD_BYTES_MAX)) begin
          count <= count + CW'(1);
        end
      end
    end
  end

  // decoded value register
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else if (item_take && item.last_byte) begin
      cand_valid <= 1'b1;
    end else if (down_ready) begin
      cand_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && item.last_byte) begin
      cand.value     <= dec_value;
      cand.bound_min <= item.bound_min;
      cand.bound_max <= item.bound_max;
    end
  end

endmodule

>>> rtl/core/tnfd_bound.sv
// bounds check and result register
module tnfd_bound (
  input  logic            clk,
  input  logic            rst,
  input  logic            cand_valid,
  input  tnfd_pkg::cand_t cand,
  input  logic            stall,
  output logic            down_ready,
  output logic            out_valid,
  output tnfd_pkg::out_t  out_data
);
  import tnfd_pkg::*;

  logic ok;

  assign down_ready = !out_valid || !stall;

  // signed range check
  assign ok = (cand.value >= cand.bound_min) && (cand.value <= cand.bound_max);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (down_ready) begin
      out_valid <= cand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (down_ready && cand_valid) begin
      out_data.value     <= ok ? cand.value : 64'sd0;
      out_data.in_bounds <= ok;
    end
  end

endmodule

>>> rtl/core/tar_numeric_field_decode_top.sv
// tar header numeric field decoder: octal text or base-256, with a bounds check
//
// The in channel takes the bytes of one numeric field, first byte first,
// one per transaction; last_byte marks the end of the field, and the
// bounds are sampled with that byte. The out channel gives one transaction
// per field: the decoded value (or 0 when outside the bounds) and in_bounds.
// Bytes past the first FIELD_BYTES_MAX of a field are ignored.
// Throughput: one byte per cycle while out_stall is low, set by the
// state update in the parser. A result passes the input register, the
// parser register and the bounds register, in that order.
// A stall on out holds the result register; the parser register still
// takes one more result, and non-last bytes keep flowing until a last byte
// finds both full, then in_stall rises. in_stall is high only while the
// input register holds a byte that cannot move on.
// Reset (rst, synchronous) empties all registers and clears the parse
// state so the next byte is taken as the first byte of a field.
module tar_numeric_field_decode_top #(
  parameter int FIELD_BYTES_MAX = tnfd_pkg::FIELD_BYTES_MAX_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tnfd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tnfd_pkg::out_t out_data
);
  import tnfd_pkg::*;

  logic  iv;
  in_t   item;
  logic  item_take;
  logic  cand_valid;
  cand_t cand;
  logic  down_ready;

  // input register
  assign in_stall = iv && !item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!in_stall) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  tnfd_parse #(
    .FIELD_BYTES_MAX (FIELD_BYTES_MAX)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .item_valid (iv),
    .item       (item),
    .down_ready (down_ready),
    .item_take  (item_take),
    .cand_valid (cand_valid),
    .cand       (cand)
  );

  tnfd_bound u_bound (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand_valid),
    .cand       (cand),
    .stall      (out_stall),
    .down_ready (down_ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // out-of-bounds results carry a zero value
  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.in_bounds |-> out_data.value == 64'sd0)
    else $error("out-of-bounds result with non-zero value");

  // a pending decoded value is not dropped while the result register is held
  a_cand_kept: assert property (@(posedge clk) disable iff (rst)
    cand_valid && !down_ready |=> cand_valid)
    else $error("decoded value lost under stall");

  // input stall only with a byte held in the input register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> iv && item.last_byte)
    else $error("input stalled without a waiting last byte");

  // nothing leaves straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !cand_valid)
    else $error("pipeline not empty after reset");

endmodule
